// ===== rtl/core/ilit_pkg.sv =====
`default_nettype none

package ilit_pkg;

   localparam int VALUE_W = 64;
   localparam int PROD_W  = VALUE_W + 4;

   // parse phases
   localparam logic [2:0] PH_START      = 3'd0;
   localparam logic [2:0] PH_AFTER_SIGN = 3'd1;
   localparam logic [2:0] PH_AFTER_ZERO = 3'd2;
   localparam logic [2:0] PH_REST_FIRST = 3'd3;
   localparam logic [2:0] PH_DIGITS     = 3'd4;

   // radix codes
   localparam logic [1:0] RX_DEC = 2'd0;
   localparam logic [1:0] RX_OCT = 2'd1;
   localparam logic [1:0] RX_HEX = 2'd2;

   // result status codes
   localparam logic [2:0] ST_OK    = 3'd0;
   localparam logic [2:0] ST_EMPTY = 3'd1;
   localparam logic [2:0] ST_SIGN  = 3'd2;
   localparam logic [2:0] ST_DIGIT = 3'd3;
   localparam logic [2:0] ST_RANGE = 3'd4;

   // result kinds
   localparam logic [2:0] KIND_INT8  = 3'd0;
   localparam logic [2:0] KIND_INT16 = 3'd1;
   localparam logic [2:0] KIND_INT32 = 3'd2;
   localparam logic [2:0] KIND_INT64 = 3'd3;
   localparam logic [2:0] KIND_UINT  = 3'd4;

   // register indexes
   localparam logic CSR_RESULT_KIND  = 1'b0;
   localparam logic CSR_UNSIGNED_MAX = 1'b1;

   // characters
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_UA    = 8'h41;
   localparam logic [7:0] CH_UZ    = 8'h5A;
   localparam logic [7:0] CH_LA    = 8'h61;
   localparam logic [7:0] CH_LZ    = 8'h7A;
   localparam logic [7:0] CH_UX    = 8'h58;
   localparam logic [7:0] CH_LX    = 8'h78;

   localparam logic [5:0] DIGIT_NONE = 6'h3F;

   // magnitude limits
   localparam logic [VALUE_W-1:0] LIM_I32_POS = 64'h0000_0000_7FFF_FFFF;
   localparam logic [VALUE_W-1:0] LIM_I32_NEG = 64'h0000_0000_8000_0000;
   localparam logic [VALUE_W-1:0] LIM_I64_POS = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [VALUE_W-1:0] LIM_I64_NEG = 64'h8000_0000_0000_0000;
   localparam logic [VALUE_W-1:0] LIM_U64     = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [VALUE_W-1:0] LIM_I16_POS = 64'd32767;
   localparam logic [VALUE_W-1:0] LIM_I16_NEG = 64'd32768;
   localparam logic [VALUE_W-1:0] LIM_I8_POS  = 64'd127;
   localparam logic [VALUE_W-1:0] LIM_I8_NEG  = 64'd128;

   typedef struct packed {
      logic capture;  // register accepted item, form acc * radix
      logic step;     // apply the character to the parse state
      logic emit;     // load result register, clear parse state
   } ctrl_cmd_type;

   typedef struct packed {
      logic ends;     // captured item closes the literal
   } dp_stat_type;

   // 0..35 for alphanumerics, DIGIT_NONE otherwise
   function automatic logic [5:0] digit_value(input logic [7:0] c);
      logic [5:0] v;
      v = DIGIT_NONE;
      if (c inside {[CH_ZERO:CH_NINE]}) v = 6'(c - CH_ZERO);
      else if (c inside {[CH_LA:CH_LZ]}) v = 6'(c - CH_LA) + 6'd10;
      else if (c inside {[CH_UA:CH_UZ]}) v = 6'(c - CH_UA) + 6'd10;
      return v;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ilit_req_if.sv =====
`default_nettype none

interface ilit_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       last_char;
   logic       empty_literal;

   modport source (output valid, output char_code, output last_char,
                   output empty_literal, input ready);
   modport sink (input valid, input char_code, input last_char,
                 input empty_literal, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ilit_rsp_if.sv =====
`default_nettype none

interface ilit_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] value_bits;
   logic [2:0]  status;

   modport source (output valid, output value_bits, output status, input ready);
   modport sink (input valid, input value_bits, input status, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ilit_ctrl.sv =====
`default_nettype none

module ilit_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid_i,
   output logic                       req_ready_o,
   output logic                       rsp_valid_o,
   input  wire logic                  rsp_ready_i,
   input  wire ilit_pkg::dp_stat_type stat_i,
   output ilit_pkg::ctrl_cmd_type     cmd_o
);
   import ilit_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_STEP = 2'd1;
   localparam logic [1:0] S_FIN  = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free    = !rsp_valid_ff || rsp_ready_i;
   assign req_ready_o = (state_ff == S_IDLE);
   assign rsp_valid_o = rsp_valid_ff;

   always_comb begin
      state_in      = state_ff;
      cmd_o         = '0;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready_i;
      case (state_ff)
         S_IDLE: begin
            if (req_valid_i) begin
               cmd_o.capture = 1'b1;
               state_in      = S_STEP;
            end
         end
         S_STEP: begin
            cmd_o.step = 1'b1;
            state_in   = stat_i.ends ? S_FIN : S_IDLE;
         end
         S_FIN: begin
            // wait here while the previous result is still held
            if (out_free) begin
               cmd_o.emit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_capture_then_step: assert property (@(posedge clock) disable iff (reset)
      cmd_o.capture |=> cmd_o.step)
      else $error("capture not followed by step");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd_o.emit |-> (!rsp_valid_ff || rsp_ready_i))
      else $error("result register overwritten");

   a_emit_shows: assert property (@(posedge clock) disable iff (reset)
      cmd_o.emit |=> rsp_valid_o)
      else $error("emitted result not presented");

endmodule

`default_nettype wire

// ===== rtl/core/ilit_dp.sv =====
`default_nettype none

module ilit_dp (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire ilit_pkg::ctrl_cmd_type cmd_i,
   output ilit_pkg::dp_stat_type       stat_o,
   input  wire logic [7:0]             char_code_i,
   input  wire logic                   last_char_i,
   input  wire logic                   empty_literal_i,
   input  wire logic                   csr_we_i,
   input  wire logic                   csr_index_i,
   input  wire logic [63:0]            csr_wdata_i,
   output logic [63:0]                 value_bits_o,
   output logic [2:0]                  status_o
);
   import ilit_pkg::*;

   // configuration
   logic [2:0]         kind_ff;
   logic [VALUE_W-1:0] umax_ff;

   // captured item
   logic [7:0]         char_ff;
   logic               last_ff;
   logic               empty_ff;
   logic [PROD_W-1:0]  prod_ff, prod_in;

   // parse state
   logic [2:0]         phase_ff, phase_in;
   logic               neg_ff, neg_in;
   logic [1:0]         radix_ff, radix_in;
   logic [VALUE_W-1:0] acc_ff, acc_in;
   logic [2:0]         err_ff, err_in;
   logic               seen_ff, seen_in;

   // result register
   logic [VALUE_W-1:0] value_ff, value_in;
   logic [2:0]         status_ff, status_in;

   logic [5:0]         dval;
   logic [4:0]         radix_val;
   logic               dig_ok;
   logic [VALUE_W-1:0] limit;
   logic [PROD_W-1:0]  sum;
   logic               over;
   logic               is_sign;
   logic               do_prefix, do_rest, do_digit;
   logic               range_bad;

   assign stat_o.ends  = last_ff || empty_ff;
   assign value_bits_o = value_ff;
   assign status_o     = status_ff;

   // acc * radix by shifts and adds
   always_comb begin
      case (radix_ff)
         RX_HEX:  prod_in = {acc_ff, 4'b0};
         RX_OCT:  prod_in = {1'b0, acc_ff, 3'b0};
         default: prod_in = {1'b0, acc_ff, 3'b0} + {3'b0, acc_ff, 1'b0};
      endcase
   end

   always_comb begin
      case (radix_ff)
         RX_HEX:  radix_val = 5'd16;
         RX_OCT:  radix_val = 5'd8;
         default: radix_val = 5'd10;
      endcase
   end

   always_comb begin
      case (kind_ff)
         KIND_UINT:  limit = LIM_U64;
         KIND_INT64: limit = neg_ff ? LIM_I64_NEG : LIM_I64_POS;
         default:    limit = neg_ff ? LIM_I32_NEG : LIM_I32_POS;
      endcase
   end

   assign dval    = digit_value(char_ff);
   assign dig_ok  = {1'b0, dval} < {2'b0, radix_val};
   assign sum     = prod_ff + {{(PROD_W-4){1'b0}}, dval[3:0]};
   assign over    = sum > {4'b0, limit};
   assign is_sign = (char_ff == CH_MINUS) || (char_ff == CH_PLUS);

   // character step
   always_comb begin
      phase_in  = phase_ff;
      neg_in    = neg_ff;
      radix_in  = radix_ff;
      acc_in    = acc_ff;
      err_in    = err_ff;
      seen_in   = seen_ff;
      do_prefix = 1'b0;
      do_rest   = 1'b0;
      do_digit  = 1'b0;
      if (cmd_i.emit) begin
         phase_in = PH_START;
         neg_in   = 1'b0;
         radix_in = RX_DEC;
         acc_in   = '0;
         err_in   = ST_OK;
         seen_in  = 1'b0;
      end else if (cmd_i.step) begin
         if (empty_ff) begin
            phase_in = PH_START;
            neg_in   = 1'b0;
            radix_in = RX_DEC;
            acc_in   = '0;
            err_in   = ST_EMPTY;
            seen_in  = 1'b0;
         end else if (err_ff == ST_OK) begin
            case (phase_ff)
               PH_START: begin
                  if (is_sign) begin
                     neg_in   = (char_ff == CH_MINUS);
                     phase_in = PH_AFTER_SIGN;
                  end else begin
                     do_prefix = 1'b1;
                  end
               end
               PH_AFTER_SIGN: begin
                  do_prefix = 1'b1;
               end
               PH_AFTER_ZERO: begin
                  if ((char_ff == CH_LX) || (char_ff == CH_UX)) begin
                     radix_in = RX_HEX;
                     phase_in = PH_REST_FIRST;
                  end else begin
                     do_rest = 1'b1;
                  end
               end
               PH_REST_FIRST: begin
                  do_rest = 1'b1;
               end
               default: begin
                  phase_in = PH_DIGITS;
                  do_digit = 1'b1;
               end
            endcase
            if (do_prefix) begin
               if (char_ff == CH_HASH) begin
                  radix_in = RX_HEX;
                  phase_in = PH_REST_FIRST;
               end else if ((char_ff == CH_ZERO) && !last_ff) begin
                  radix_in = RX_OCT;
                  phase_in = PH_AFTER_ZERO;
               end else begin
                  radix_in = RX_DEC;
                  do_rest  = 1'b1;
               end
            end
            if (do_rest) begin
               phase_in = PH_DIGITS;
               if (is_sign) err_in = ST_SIGN;
               else do_digit = 1'b1;
            end
            if (do_digit) begin
               if (!dig_ok || over) begin
                  err_in = ST_DIGIT;
               end else begin
                  acc_in  = sum[VALUE_W-1:0];
                  seen_in = 1'b1;
               end
            end
         end
      end
   end

   // final range check and sign
   always_comb begin
      range_bad = 1'b0;
      case (kind_ff)
         KIND_UINT:  range_bad = (neg_ff && (acc_ff != '0)) || (acc_ff > umax_ff);
         KIND_INT8:  range_bad = acc_ff > (neg_ff ? LIM_I8_NEG : LIM_I8_POS);
         KIND_INT16: range_bad = acc_ff > (neg_ff ? LIM_I16_NEG : LIM_I16_POS);
         default:    range_bad = 1'b0;
      endcase
      value_in  = '0;
      status_in = err_ff;
      if (status_in == ST_OK && !seen_ff) status_in = ST_DIGIT;
      if (status_in == ST_OK) begin
         if (range_bad) status_in = ST_RANGE;
         else if (kind_ff == KIND_UINT || !neg_ff) value_in = acc_ff;
         else value_in = '0 - acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff  <= KIND_INT32;
         umax_ff  <= LIM_U64;
         phase_ff <= PH_START;
         neg_ff   <= 1'b0;
         radix_ff <= RX_DEC;
         acc_ff   <= '0;
         err_ff   <= ST_OK;
         seen_ff  <= 1'b0;
      end else begin
         if (csr_we_i && csr_index_i == CSR_RESULT_KIND) kind_ff <= csr_wdata_i[2:0];
         if (csr_we_i && csr_index_i == CSR_UNSIGNED_MAX) umax_ff <= csr_wdata_i;
         phase_ff <= phase_in;
         neg_ff   <= neg_in;
         radix_ff <= radix_in;
         acc_ff   <= acc_in;
         err_ff   <= err_in;
         seen_ff  <= seen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_i.capture) begin
         char_ff  <= char_code_i;
         last_ff  <= last_char_i;
         empty_ff <= empty_literal_i;
         prod_ff  <= prod_in;
      end
      if (cmd_i.emit) begin
         value_ff  <= value_in;
         status_ff <= status_in;
      end
   end

   a_error_latches: assert property (@(posedge clock) disable iff (reset)
      (cmd_i.step && !empty_ff && err_ff != ST_OK) |=>
         (err_ff == $past(err_ff) && acc_ff == $past(acc_ff)))
      else $error("latched error disturbed");

   a_emit_clears: assert property (@(posedge clock) disable iff (reset)
      cmd_i.emit |=> (err_ff == ST_OK && acc_ff == '0 && !seen_ff))
      else $error("parse state not cleared after result");

   a_seen_not_err: assert property (@(posedge clock) disable iff (reset)
      (seen_ff && !$past(seen_ff) && !$past(reset)) |-> err_ff == ST_OK)
      else $error("digit taken while in error");

endmodule

`default_nettype wire

// ===== rtl/core/integer_literal_decoder.sv =====
`default_nettype none

// Channel  Dir  Payload                                    Handshake
// req_ch   in   char_code[7:0] last_char empty_literal     valid/ready
// rsp_ch   out  value_bits[63:0] status[2:0]               valid/ready
// csr_*    in   csr_index[0] csr_wdata[63:0]               csr_we, no stall
//
// Each character is captured, then stepped; the last one also passes a final
// state that loads the result register. The digit update is split over two
// registers: acc * radix by shifts and adds, then add digit and limit compare.
// The result register lets the next literal start while a result waits;
// only a new result stalls in the final state until the held one is taken.
// Reset (synchronous) restores result_kind = int32, unsigned_max = all ones
// and an empty parse state.

module integer_literal_decoder (
   input  wire logic   clock,
   input  wire logic   reset,
   ilit_req_if.sink    req_ch,
   ilit_rsp_if.source  rsp_ch,
   input  wire logic   csr_we,
   input  wire logic   csr_index,
   input  wire logic [63:0] csr_wdata
);
   import ilit_pkg::*;

   ctrl_cmd_type cmd;
   dp_stat_type  stat;

   // sequencer: handshakes and per-item cycle order
   ilit_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid_i (req_ch.valid),
      .req_ready_o (req_ch.ready),
      .rsp_valid_o (rsp_ch.valid),
      .rsp_ready_i (rsp_ch.ready),
      .stat_i      (stat),
      .cmd_o       (cmd)
   );

   // parse state, accumulator, limit checks, result register, CSRs
   ilit_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd_i           (cmd),
      .stat_o          (stat),
      .char_code_i     (req_ch.char_code),
      .last_char_i     (req_ch.last_char),
      .empty_literal_i (req_ch.empty_literal),
      .csr_we_i        (csr_we),
      .csr_index_i     (csr_index),
      .csr_wdata_i     (csr_wdata),
      .value_bits_o    (rsp_ch.value_bits),
      .status_o        (rsp_ch.status)
   );

endmodule

`default_nettype wire
